[hdl/tea_pkg.sv]
// tea_pkg: shared types, register codes and compare helper for the threshold event alarm
// used by tea_cfg, tea_core and threshold_event_alarm; no dependencies
package tea_pkg;

    // rule state
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ON   = 2'd1,
        ST_HELD = 2'd2
    } alarm_state_t;

    // reported event kinds
    typedef enum logic [1:0] {
        KIND_RAISE  = 2'd0,
        KIND_REPEAT = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_ACK    = 2'd3
    } event_type_t;

    // compare operators for reading and gate
    typedef enum logic [1:0] {
        CMP_GE = 2'd0,
        CMP_LE = 2'd1,
        CMP_GT = 2'd2,
        CMP_LT = 2'd3
    } cmp_op_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE           = 3'd0,
        REG_COMPARE_OP     = 3'd1,
        REG_THRESHOLD      = 3'd2,
        REG_HYSTERESIS_PCT = 3'd3,
        REG_DEBOUNCE_COUNT = 3'd4,
        REG_COOLDOWN_SEC   = 3'd5,
        REG_GATE_OP        = 3'd6,
        REG_GATE_LIMIT     = 3'd7
    } reg_index_t;

    // input item kinds
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_ACK    = 1'b1
    } item_op_t;

    // mode register bits
    localparam int MODE_EVENT = 0;
    localparam int MODE_LATCH = 1;
    localparam int MODE_GATE  = 2;

    // widened width for the clear band compare (100 * reading and friends)
    localparam int WIDE_W = 41;

    // reset values of the registers
    localparam logic [2:0]  RST_MODE       = 3'd0;
    localparam logic [31:0] RST_THRESHOLD  = 32'd0;
    localparam logic [6:0]  RST_HYST_PCT   = 7'd10;
    localparam logic [7:0]  RST_DEBOUNCE   = 8'd2;
    localparam logic [15:0] RST_COOLDOWN   = 16'd60;
    localparam logic [31:0] RST_GATE_LIMIT = 32'd0;
    localparam logic [31:0] RST_COOL_MS    = 32'd60000;

    typedef struct packed {
        logic [2:0]               mode;
        cmp_op_t                  compare_op;
        logic signed [31:0]       threshold;
        logic [7:0]               debounce_count;
        cmp_op_t                  gate_op;
        logic signed [31:0]       gate_limit;
        logic signed [WIDE_W-1:0] clear_limit;   // 100*thr -/+ |thr|*pct
        logic [31:0]              cooldown_ms;
    } cfg_t;

    typedef struct packed {
        item_op_t           op;
        logic signed [31:0] reading;
        logic               gate_present;
        logic signed [31:0] gate_reading;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic               emit;
        event_type_t        event_type;
        logic signed [31:0] event_value;
    } result_t;

    function automatic logic cmp_hit(logic signed [31:0] v, cmp_op_t op,
                                     logic signed [31:0] t);
        logic hit;
        unique case (op)
            CMP_GE:  hit = (v >= t);
            CMP_LE:  hit = (v <= t);
            CMP_GT:  hit = (v > t);
            CMP_LT:  hit = (v < t);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

[hdl/tea_cfg.sv]
// tea_cfg: configuration registers and registered derived limits
// depends on tea_pkg
module tea_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [31:0]         wr_data,
    output tea_pkg::cfg_t       cfg
);

    logic [2:0]          mode_reg;
    tea_pkg::cmp_op_t    compare_op_reg;
    logic signed [31:0]  threshold_reg;
    logic [6:0]          hyst_pct_reg;
    logic [7:0]          debounce_reg;
    logic [15:0]         cooldown_reg;
    tea_pkg::cmp_op_t    gate_op_reg;
    logic signed [31:0]  gate_limit_reg;

    logic signed [tea_pkg::WIDE_W-1:0] clear_limit_reg;
    logic signed [tea_pkg::WIDE_W-1:0] clear_limit_next;
    logic [31:0]                       cool_ms_reg;
    logic [31:0]                       cool_ms_next;

    logic [31:0]                       thr_mag;
    logic [38:0]                       band;
    logic signed [tea_pkg::WIDE_W-1:0] thr_wide;
    logic signed [tea_pkg::WIDE_W-1:0] thr_100;
    logic signed [tea_pkg::WIDE_W-1:0] band_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= tea_pkg::RST_MODE;
            compare_op_reg <= tea_pkg::CMP_GE;
            threshold_reg  <= tea_pkg::RST_THRESHOLD;
            hyst_pct_reg   <= tea_pkg::RST_HYST_PCT;
            debounce_reg   <= tea_pkg::RST_DEBOUNCE;
            cooldown_reg   <= tea_pkg::RST_COOLDOWN;
            gate_op_reg    <= tea_pkg::CMP_LE;
            gate_limit_reg <= tea_pkg::RST_GATE_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (tea_pkg::reg_index_t'(wr_index))
                tea_pkg::REG_MODE:           mode_reg       <= wr_data[2:0];
                tea_pkg::REG_COMPARE_OP:     compare_op_reg <= tea_pkg::cmp_op_t'(wr_data[1:0]);
                tea_pkg::REG_THRESHOLD:      threshold_reg  <= wr_data;
                tea_pkg::REG_HYSTERESIS_PCT: hyst_pct_reg   <= wr_data[6:0];
                tea_pkg::REG_DEBOUNCE_COUNT: debounce_reg   <= wr_data[7:0];
                tea_pkg::REG_COOLDOWN_SEC:   cooldown_reg   <= wr_data[15:0];
                tea_pkg::REG_GATE_OP:        gate_op_reg    <= tea_pkg::cmp_op_t'(wr_data[1:0]);
                tea_pkg::REG_GATE_LIMIT:     gate_limit_reg <= wr_data;
                default:                     mode_reg       <= mode_reg;
            endcase
        end
    end

    // clear band limit: exact, widened so nothing overflows
    always_comb
    begin
        thr_mag   = threshold_reg[31] ? (~threshold_reg + 32'd1) : threshold_reg;
        band      = {7'd0, thr_mag} * {32'd0, hyst_pct_reg};
        thr_wide  = {{(tea_pkg::WIDE_W-32){threshold_reg[31]}}, threshold_reg};
        thr_100   = thr_wide * 41'sd100;
        band_wide = {{(tea_pkg::WIDE_W-39){1'b0}}, band};
        if (compare_op_reg == tea_pkg::CMP_GE || compare_op_reg == tea_pkg::CMP_GT)
            clear_limit_next = thr_100 - band_wide;
        else
            clear_limit_next = thr_100 + band_wide;
        cool_ms_next = {16'd0, cooldown_reg} * 32'd1000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_limit_reg <= '0;
            cool_ms_reg     <= tea_pkg::RST_COOL_MS;
        end
        else
        begin
            clear_limit_reg <= clear_limit_next;
            cool_ms_reg     <= cool_ms_next;
        end
    end

    always_comb
    begin
        cfg.mode           = mode_reg;
        cfg.compare_op     = compare_op_reg;
        cfg.threshold      = threshold_reg;
        cfg.debounce_count = debounce_reg;
        cfg.gate_op        = gate_op_reg;
        cfg.gate_limit     = gate_limit_reg;
        cfg.clear_limit    = clear_limit_reg;
        cfg.cooldown_ms    = cool_ms_reg;
    end

endmodule

[hdl/tea_core.sv]
// tea_core: alarm rule state and per-item decision logic
// depends on tea_pkg
module tea_core (
    input  logic                clk,
    input  logic                rst_n,
    input  tea_pkg::cfg_t       cfg,
    input  tea_pkg::item_t      item,
    input  logic                advance,
    output tea_pkg::result_t    result
);

    tea_pkg::alarm_state_t alarm_state_reg;
    tea_pkg::alarm_state_t alarm_state_next;
    logic [7:0]            run_reg;
    logic [7:0]            run_next;
    logic [31:0]           notify_reg;
    logic [31:0]           notify_next;
    logic signed [31:0]    prev_reg;
    logic                  have_prev_reg;

    logic                          is_event;
    logic                          latch;
    logic                          gate_ok;
    logic                          trip;
    logic                          cond;
    logic                          cool_ok;
    logic                          clear_hit;
    logic [31:0]                   elapsed;
    logic [7:0]                    need;
    logic [7:0]                    run_inc;
    logic signed [tea_pkg::WIDE_W-1:0] v_wide;
    logic signed [tea_pkg::WIDE_W-1:0] v_100;

    assign is_event = cfg.mode[tea_pkg::MODE_EVENT];
    assign latch    = cfg.mode[tea_pkg::MODE_LATCH];
    assign gate_ok  = !cfg.mode[tea_pkg::MODE_GATE] ||
                      (item.gate_present &&
                       tea_pkg::cmp_hit(item.gate_reading, cfg.gate_op, cfg.gate_limit));
    assign trip     = tea_pkg::cmp_hit(item.reading, cfg.compare_op, cfg.threshold) && gate_ok;
    assign cond     = is_event ? (have_prev_reg && (item.reading > prev_reg) && gate_ok) : trip;
    assign elapsed  = item.now_ms - notify_reg;
    assign cool_ok  = (notify_reg == 32'd0) || (elapsed >= cfg.cooldown_ms);
    assign need     = (cfg.debounce_count == 8'd0) ? 8'd1 : cfg.debounce_count;
    assign run_inc  = run_reg + 8'd1;
    assign v_wide   = {{(tea_pkg::WIDE_W-32){item.reading[31]}}, item.reading};
    assign v_100    = v_wide * 41'sd100;
    assign clear_hit = (cfg.compare_op == tea_pkg::CMP_GE || cfg.compare_op == tea_pkg::CMP_GT)
                       ? (v_100 < cfg.clear_limit) : (v_100 > cfg.clear_limit);

    // next state
    always_comb
    begin
        alarm_state_next = alarm_state_reg;
        if (item.op == tea_pkg::OP_ACK)
        begin
            if (alarm_state_reg == tea_pkg::ST_HELD)
                alarm_state_next = tea_pkg::ST_IDLE;
        end
        else
        begin
            unique case (alarm_state_reg)
                tea_pkg::ST_ON:
                begin
                    if (clear_hit)
                        alarm_state_next = latch ? tea_pkg::ST_HELD : tea_pkg::ST_IDLE;
                end
                tea_pkg::ST_HELD:
                    alarm_state_next = tea_pkg::ST_HELD;
                default:
                begin
                    if (cond && is_event && cool_ok && latch)
                        alarm_state_next = tea_pkg::ST_HELD;
                    else if (cond && !is_event && run_inc >= need)
                        alarm_state_next = tea_pkg::ST_ON;
                end
            endcase
        end
    end

    // outputs and datapath updates
    always_comb
    begin
        result.emit        = 1'b0;
        result.event_type  = tea_pkg::KIND_RAISE;
        result.event_value = item.reading;
        run_next           = run_reg;
        notify_next        = notify_reg;
        if (item.op == tea_pkg::OP_ACK)
        begin
            if (alarm_state_reg == tea_pkg::ST_HELD)
            begin
                result.emit        = 1'b1;
                result.event_type  = tea_pkg::KIND_ACK;
                result.event_value = prev_reg;
                run_next           = 8'd0;
            end
        end
        else
        begin
            unique case (alarm_state_reg)
                tea_pkg::ST_ON:
                begin
                    if (clear_hit)
                    begin
                        result.emit       = 1'b1;
                        result.event_type = tea_pkg::KIND_CLEAR;
                        run_next          = 8'd0;
                    end
                    else if (cool_ok)
                    begin
                        result.emit       = 1'b1;
                        result.event_type = tea_pkg::KIND_REPEAT;
                        notify_next       = item.now_ms;
                    end
                end
                tea_pkg::ST_HELD:
                begin
                    if (!is_event && trip && cool_ok)
                    begin
                        result.emit = 1'b1;
                        notify_next = item.now_ms;
                    end
                end
                default:
                begin
                    if (!cond)
                        run_next = 8'd0;
                    else if (is_event)
                    begin
                        if (cool_ok)
                        begin
                            result.emit = 1'b1;
                            notify_next = item.now_ms;
                        end
                    end
                    else if (run_inc >= need)
                    begin
                        result.emit = 1'b1;
                        notify_next = item.now_ms;
                        run_next    = 8'd0;
                    end
                    else
                        run_next = run_inc;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_state_reg <= tea_pkg::ST_IDLE;
            run_reg         <= 8'd0;
            notify_reg      <= 32'd0;
            prev_reg        <= 32'sd0;
            have_prev_reg   <= 1'b0;
        end
        else if (advance)
        begin
            alarm_state_reg <= alarm_state_next;
            run_reg         <= run_next;
            notify_reg      <= notify_next;
            if (item.op == tea_pkg::OP_SAMPLE)
            begin
                prev_reg      <= item.reading;
                have_prev_reg <= 1'b1;
            end
        end
    end

endmodule

[hdl/threshold_event_alarm.sv]
// threshold_event_alarm: top level of the single-rule threshold / event alarm
// depends on tea_pkg, tea_cfg and tea_core
//
// One alarm rule fed by a stream of words. A sample word carries a signed Q16.16 reading,
// an optional gate reading and a wrapping millisecond timestamp; an acknowledge word
// releases a latched alarm. Each accepted word yields at most one result word (raised,
// renotify, cleared or acknowledged, with the reading it reports). The block takes one
// word per cycle while its results are taken: a word is registered at the input, decided
// by the combinational rule logic against the current state, and its result lands in the
// output register, which drives m_tvalid. The output register lets the next word be
// decided while the sink is ready; when a result sits untaken, the input register holds
// and s_tready drops. Configuration writes are always taken (cfg_ready is tied high) and
// must be made while no word is in flight; the clear band limit and cooldown in
// milliseconds are rebuilt in a register in the cycle after a write.
module threshold_event_alarm (
    input  logic         clk,
    input  logic         rst_n,

    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,    // reading[31:0], gate_present[32],
                                     // gate_reading[64:33], now_ms[96:65], zero pad
    input  logic [0:0]   s_tuser,    // op[0]: 0 sample, 1 acknowledge

    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,    // event_value[31:0]
    output logic [1:0]   m_tuser,    // event_type[1:0]

    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    tea_pkg::cfg_t    cfg;
    tea_pkg::item_t   item_reg;
    tea_pkg::result_t result;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         out_type_reg;
    logic signed [31:0] out_value_reg;
    logic               advance;
    logic               in_take;

    assign cfg_ready = 1'b1;

    tea_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // the held word is decided when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = in_take || (in_valid_reg && !advance);
        out_valid_next = (advance && result.emit) || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input word register, payload only
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op           <= tea_pkg::item_op_t'(s_tuser[0]);
            item_reg.reading      <= s_tdata[31:0];
            item_reg.gate_present <= s_tdata[32];
            item_reg.gate_reading <= s_tdata[64:33];
            item_reg.now_ms       <= s_tdata[96:65];
        end
    end

    tea_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (result)
    );

    // result word register, payload only
    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_type_reg  <= result.event_type;
            out_value_reg <= result.event_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_type_reg;

endmodule
